### rtl/pls_pkg.sv
// positional list store: shared constants, codes and structs
// no dependencies; used by every other file of the block

package pls_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_GET    = 2'd2,
      OP_LOCATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_RANGE    = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_COLLECT
   } state_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic                     sample;
      logic                     insert_en;
      logic                     delete_en;
      logic [IDX_W-1:0]         sel_index;
      logic signed [DATA_W-1:0] item_value;
      logic [LEN_W-1:0]         length;
   } cell_cmd_type;

endpackage

### rtl/pls_if.sv
// request and response channel interfaces of the positional list store
// depends on pls_pkg

interface pls_req_if;
   logic                              valid;
   logic                              ready;
   pls_pkg::op_type                   op;
   logic [pls_pkg::POS_W-1:0]         position;
   logic signed [pls_pkg::DATA_W-1:0] item_value;

   modport source (output valid, output op, output position, output item_value, input ready);
   modport sink   (input valid, input op, input position, input item_value, output ready);
endinterface

interface pls_rsp_if;
   logic                              valid;
   logic                              ready;
   pls_pkg::status_type               status;
   logic signed [pls_pkg::DATA_W-1:0] read_value;
   logic [pls_pkg::IDX_W-1:0]         found_index;
   logic [pls_pkg::LEN_W-1:0]         current_length;

   modport source (output valid, output status, output read_value, output found_index,
                   output current_length, input ready);
   modport sink   (input valid, input status, input read_value, input found_index,
                   input current_length, output ready);
endinterface

### rtl/pls_cell.sv
// one list entry: shifts with its neighbours, compares and selects locally
// depends on pls_pkg

module pls_cell (
   input  logic                              clock,
   input  pls_pkg::cell_cmd_type             cmd,
   input  logic [pls_pkg::IDX_W-1:0]         cell_index,
   input  logic signed [pls_pkg::DATA_W-1:0] prev_entry,
   input  logic signed [pls_pkg::DATA_W-1:0] next_entry,
   output logic signed [pls_pkg::DATA_W-1:0] entry_out,
   output logic                              hit_out,
   output logic signed [pls_pkg::DATA_W-1:0] pick_out
);

   logic signed [pls_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic                              hit_ff, hit_in;
   logic signed [pls_pkg::DATA_W-1:0] pick_ff, pick_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert_en) begin
         if (cell_index == cmd.sel_index) begin
            entry_in = cmd.item_value;
         end else if (cell_index > cmd.sel_index) begin
            entry_in = prev_entry;
         end
      end else if (cmd.delete_en && (cell_index >= cmd.sel_index)) begin
         entry_in = next_entry;
      end
   end

   // compare and select see the entry before any shift
   assign hit_in  = (entry_ff == cmd.item_value) &&
                    ({1'b0, cell_index} < pls_pkg::LEN_W'(cmd.length));
   assign pick_in = (cell_index == cmd.sel_index) ? entry_ff : '0;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.sample) begin
         hit_ff  <= hit_in;
         pick_ff <= pick_in;
      end
   end

   assign entry_out = entry_ff;
   assign hit_out   = hit_ff;
   assign pick_out  = pick_ff;

endmodule

### rtl/pls_collect.sv
// reduces the registered cell outputs: first match index and selected entry
// depends on pls_pkg

module pls_collect (
   input  logic [pls_pkg::CAPACITY-1:0]      hit_vec,
   input  logic signed [pls_pkg::DATA_W-1:0] pick_vec [pls_pkg::CAPACITY],
   output logic                              any_hit,
   output logic [pls_pkg::IDX_W-1:0]         first_index,
   output logic signed [pls_pkg::DATA_W-1:0] picked_value
);

   logic [pls_pkg::CAPACITY-1:0] first_onehot;

   // lowest set bit isolated
   assign first_onehot = hit_vec & (~hit_vec + pls_pkg::CAPACITY'(1));
   assign any_hit      = |hit_vec;

   always_comb begin
      first_index  = '0;
      picked_value = '0;
      for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
         first_index  = first_index  | (pls_pkg::IDX_W'(i) & {pls_pkg::IDX_W{first_onehot[i]}});
         picked_value = picked_value | pick_vec[i];
      end
   end

endmodule

### rtl/positional_list_store.sv
// positional list store top level: control, length register, row of cells, reduction
// a request transfer updates the cell row, samples its compare/select outputs and enters
// S_COLLECT, where the match/select reduction runs; the response register loads once the
// response slot is free, and no new request is taken until it has loaded
// reset: clears length, state and response valid; entries are left as they are
// depends on pls_pkg, pls_if, pls_cell, pls_collect

module positional_list_store (
   input  logic       clock,
   input  logic       reset,
   pls_req_if.sink    req_ch,
   pls_rsp_if.source  rsp_ch
);

   pls_pkg::state_type                state_ff, state_in;
   logic [pls_pkg::LEN_W-1:0]         length_ff, length_in;
   pls_pkg::op_type                   op_ff;
   pls_pkg::status_type               status_ff, status_in;
   logic                              rsp_valid_ff;
   pls_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic signed [pls_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [pls_pkg::IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [pls_pkg::LEN_W-1:0]         rsp_length_ff;

   logic                  accept;
   logic                  slot_free;
   logic                  load_rsp;
   logic                  req_ready;
   logic                  bad_insert_pos;
   logic                  bad_read_pos;
   pls_pkg::cell_cmd_type cmd;

   logic signed [pls_pkg::DATA_W-1:0] entry_vec [pls_pkg::CAPACITY];
   logic signed [pls_pkg::DATA_W-1:0] pick_vec  [pls_pkg::CAPACITY];
   logic [pls_pkg::CAPACITY-1:0]      hit_vec;
   logic                              any_hit;
   logic [pls_pkg::IDX_W-1:0]         first_index;
   logic signed [pls_pkg::DATA_W-1:0] picked_value;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pls_pkg::S_IDLE: begin
            if (accept) state_in = pls_pkg::S_COLLECT;
         end
         pls_pkg::S_COLLECT: begin
            if (slot_free) state_in = pls_pkg::S_IDLE;
         end
         default: state_in = pls_pkg::S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         pls_pkg::S_IDLE:    req_ready = 1'b1;
         pls_pkg::S_COLLECT: load_rsp  = slot_free;
         default: begin
            req_ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   // position checks against the length before the operation
   assign bad_insert_pos = (req_ch.position == '0) ||
      (pls_pkg::CMP_W'(req_ch.position) > (pls_pkg::CMP_W'(length_ff) + pls_pkg::CMP_W'(1)));
   assign bad_read_pos = (req_ch.position == '0) ||
      (pls_pkg::CMP_W'(req_ch.position) > pls_pkg::CMP_W'(length_ff));

   always_comb begin
      status_in = pls_pkg::STAT_OK;
      case (req_ch.op)
         pls_pkg::OP_INSERT: begin
            if (bad_insert_pos) begin
               status_in = pls_pkg::STAT_RANGE;
            end else if (pls_pkg::CMP_W'(length_ff) >= pls_pkg::CMP_W'(pls_pkg::CAPACITY)) begin
               status_in = pls_pkg::STAT_FULL;
            end
         end
         pls_pkg::OP_DELETE, pls_pkg::OP_GET: begin
            if (bad_read_pos) status_in = pls_pkg::STAT_RANGE;
         end
         default: status_in = pls_pkg::STAT_OK;
      endcase
   end

   always_comb begin
      cmd.sample     = accept;
      cmd.insert_en  = accept && (req_ch.op == pls_pkg::OP_INSERT) &&
                       (status_in == pls_pkg::STAT_OK);
      cmd.delete_en  = accept && (req_ch.op == pls_pkg::OP_DELETE) &&
                       (status_in == pls_pkg::STAT_OK);
      cmd.sel_index  = pls_pkg::IDX_W'(req_ch.position - pls_pkg::POS_W'(1));
      cmd.item_value = req_ch.item_value;
      cmd.length     = length_ff;
   end

   always_comb begin
      length_in = length_ff;
      if (cmd.insert_en) begin
         length_in = length_ff + pls_pkg::LEN_W'(1);
      end else if (cmd.delete_en) begin
         length_in = length_ff - pls_pkg::LEN_W'(1);
      end
   end

   // row of cells, each wired to its neighbours
   for (genvar g = 0; g < pls_pkg::CAPACITY; g++) begin : g_cell
      logic signed [pls_pkg::DATA_W-1:0] prev_entry;
      logic signed [pls_pkg::DATA_W-1:0] next_entry;

      if (g == 0) begin : g_first
         assign prev_entry = '0;
      end else begin : g_mid_lo
         assign prev_entry = entry_vec[g-1];
      end
      if (g == pls_pkg::CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_mid_hi
         assign next_entry = entry_vec[g+1];
      end

      pls_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (pls_pkg::IDX_W'(g)),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry_out  (entry_vec[g]),
         .hit_out    (hit_vec[g]),
         .pick_out   (pick_vec[g])
      );
   end

   pls_collect u_collect (
      .hit_vec      (hit_vec),
      .pick_vec     (pick_vec),
      .any_hit      (any_hit),
      .first_index  (first_index),
      .picked_value (picked_value)
   );

   always_comb begin
      rsp_status_in = status_ff;
      rsp_value_in  = '0;
      rsp_index_in  = '0;
      case (op_ff)
         pls_pkg::OP_LOCATE: begin
            if (any_hit) begin
               rsp_index_in = first_index;
            end else begin
               rsp_status_in = pls_pkg::STAT_NOTFOUND;
            end
         end
         pls_pkg::OP_DELETE, pls_pkg::OP_GET: begin
            if (status_ff == pls_pkg::STAT_OK) rsp_value_in = picked_value;
         end
         default: rsp_status_in = status_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pls_pkg::S_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         length_ff <= length_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_ch.op;
         status_ff <= status_in;
      end
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_length_ff <= length_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.read_value     = rsp_value_ff;
   assign rsp_ch.found_index    = rsp_index_ff;
   assign rsp_ch.current_length = rsp_length_ff;

endmodule

### rtl/pls_checker.sv
// port-level checks for the positional list store, bound to the top level
// depends on pls_pkg and positional_list_store

module pls_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input pls_pkg::status_type               rsp_status,
   input logic signed [pls_pkg::DATA_W-1:0] rsp_read_value,
   input logic [pls_pkg::IDX_W-1:0]         rsp_found_index,
   input logic [pls_pkg::LEN_W-1:0]         rsp_current_length
);

   // one item in flight: no transfer directly after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken on consecutive cycles");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_current_length <= pls_pkg::LEN_W'(pls_pkg::CAPACITY)))
      else $error("length above capacity");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == pls_pkg::STAT_FULL)) |->
      (rsp_current_length == pls_pkg::LEN_W'(pls_pkg::CAPACITY)))
      else $error("full status with spare room");

   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == pls_pkg::STAT_RANGE) ||
                     (rsp_status == pls_pkg::STAT_NOTFOUND) ||
                     (rsp_status == pls_pkg::STAT_FULL))) |->
      ((rsp_read_value == '0) && (rsp_found_index == '0)))
      else $error("failed operation returns data");

   a_index_in_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_found_index != '0)) |->
      (pls_pkg::LEN_W'(rsp_found_index) < rsp_current_length))
      else $error("match index beyond list end");

endmodule

bind positional_list_store pls_checker u_pls_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_status         (rsp_ch.status),
   .rsp_read_value     (rsp_ch.read_value),
   .rsp_found_index    (rsp_ch.found_index),
   .rsp_current_length (rsp_ch.current_length)
);
